// ----- sv/gtpr_pkg.sv -----
// ----------------------------------------------------------------------------
// gtpr_pkg
// shared types, constants and font tables of the glyph text pixel renderer
// ----------------------------------------------------------------------------
`default_nettype none

package gtpr_pkg;

    localparam int CODE_W   = 7;
    localparam int POS_W    = 10;
    localparam int LW_W     = 11;
    localparam int ADDR_W   = 24;
    localparam int PIX_W    = 16;
    localparam int CFG_W    = 24;
    localparam int ROWS     = 7;
    localparam int COLS     = 6;
    localparam int BITMAP_W = ROWS * COLS;

    localparam logic [2:0] LAST_ROW = 3'(ROWS - 1);
    localparam logic [2:0] LAST_COL = 3'(COLS - 1);

    localparam logic [7:0]       GLYPH_NONE = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_SET    = 16'hFFFF;
    localparam logic [PIX_W-1:0] PIX_CLEAR  = 16'h0001;

    // configuration register indexes
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_FRAME_BASE = 1'b1;

    localparam logic [7:0] CODE_TO_GLYPH [0:127] = '{
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'h29,8'hFF,8'hFF,8'hFF,8'h2B,8'hFF,8'hFF,
        8'h25,8'h26,8'hFF,8'h2A,8'hFF,8'h27,8'h2C,8'hFF,
        8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h24,8'hFF,8'hFF,8'hFF,8'hFF,8'h28,
        8'hFF,8'h0A,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h10,
        8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,
        8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h1E,8'h1F,8'h20,
        8'h21,8'h22,8'h23,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'h0A,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h10,
        8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,
        8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h1E,8'h1F,8'h20,
        8'h21,8'h22,8'h23,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF
    };

    localparam logic [31:0] FONT_ROM [0:63] = '{
        32'h70871C30, 32'h8988A250, 32'h88808290, 32'h88831C90,
        32'h888402F8, 32'h88882210, 32'h71CF9C10, 32'hF9CF9C70,
        32'h8228A288, 32'hF200A288, 32'h0BC11C78, 32'h0A222208,
        32'h8A222288, 32'h71C21C70, 32'h23C738F8, 32'h5228A480,
        32'h8A282280, 32'h8BC822F0, 32'hFA282280, 32'h8A28A480,
        32'h8BC738F8, 32'hF9C89C08, 32'h82288808, 32'h82088808,
        32'hF2EF8808, 32'h82288888, 32'h82288888, 32'h81C89C70,
        32'h8A08A270, 32'h920DA288, 32'hA20AB288, 32'hC20AAA88,
        32'hA208A688, 32'h9208A288, 32'h8BE8A270, 32'hF1CF1CF8,
        32'h8A28A220, 32'h8A28A020, 32'hF22F1C20, 32'h82AA0220,
        32'h82492220, 32'h81A89C20, 32'h8A28A288, 32'h8A28A288,
        32'h8A289488, 32'h8A2A8850, 32'h894A9420, 32'h894AA220,
        32'h70852220, 32'hF8011000, 32'h08020800, 32'h10840400,
        32'h20040470, 32'h40840400, 32'h80020800, 32'hF8011000,
        32'h70800000, 32'h88822200, 32'h08820400, 32'h108F8800,
        32'h20821000, 32'h00022200, 32'h20800020, 32'h00000000
    };

    typedef struct packed {
        logic                  mapped;
        logic [BITMAP_W-1:0]   bitmap;
        logic [ADDR_W-1:0]     base_addr;
        logic [LW_W-1:0]       step;
    } job_t;

    // row 0 col 0 lands in the top bit, rows follow left to right
    function automatic logic [BITMAP_W-1:0] glyph_bitmap(input logic [5:0] word_base,
                                                         input logic [2:0] slot);
        logic [BITMAP_W-1:0] bm;
        logic [31:0]         word;
        logic [5:0]          idx;
        logic [4:0]          sh;
        bm = '0;
        sh = 5'(26 - COLS * int'(slot));
        for (int r = 0; r < ROWS; r++)
        begin
            idx = word_base + 6'(r);
            word = FONT_ROM[idx];
            bm[BITMAP_W-1-r*COLS -: COLS] = COLS'(word >> sh);
        end
        return bm;
    endfunction

endpackage

`default_nettype wire

// ----- sv/gtpr_decode.sv -----
// ----------------------------------------------------------------------------
// gtpr_decode
// maps a character code to its glyph bitmap and the address of its first pixel
// ----------------------------------------------------------------------------
`default_nettype none

module gtpr_decode #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  wire logic [gtpr_pkg::CODE_W-1:0] code,
    input  wire logic [gtpr_pkg::POS_W-1:0]  x_pos,
    input  wire logic [gtpr_pkg::POS_W-1:0]  y_pos,
    input  wire logic [gtpr_pkg::LW_W-1:0]   line_width,
    input  wire logic [gtpr_pkg::ADDR_W-1:0] frame_base,
    output gtpr_pkg::job_t                   job
);
    import gtpr_pkg::*;

    logic [7:0]             glyph8;
    logic [5:0]             glyph;
    logic [9:0]             prod;
    logic [3:0]             quot;
    logic [2:0]             slot;
    logic [5:0]             word_base;
    logic [LW_W-1:0]        step;
    logic [LW_W+POS_W-1:0]  row_offset;

    always_comb
    begin
        glyph8    = CODE_TO_GLYPH[code];
        glyph     = glyph8[5:0];
        // divide by five through a reciprocal, exact for glyph numbers below 64
        prod      = 10'(glyph) * 10'd13;
        quot      = prod[9:6];
        slot      = 3'(glyph - 6'(quot) * 6'd5);
        word_base = 6'(quot) * 6'(ROWS);

        if (32'(line_width) > MAX_LINE_WIDTH)
        begin
            step = LW_W'(MAX_LINE_WIDTH);
        end
        else
        begin
            step = line_width;
        end
        row_offset = (LW_W+POS_W)'(step) * (LW_W+POS_W)'(y_pos);

        job.mapped    = (glyph8 != GLYPH_NONE);
        job.bitmap    = glyph_bitmap(word_base, slot);
        job.base_addr = frame_base + ADDR_W'(row_offset) + ADDR_W'(x_pos);
        job.step      = step;
    end

endmodule

`default_nettype wire

// ----- sv/gtpr_pixel_seq.sv -----
// ----------------------------------------------------------------------------
// gtpr_pixel_seq
// walks a glyph row by row and column by column, one pixel write per cycle
// unless out_stall holds, into an output register
// ----------------------------------------------------------------------------
`default_nettype none

module gtpr_pixel_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire gtpr_pkg::job_t              job,
    input  wire logic                        load_valid,
    output logic                             load_ready,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [gtpr_pkg::ADDR_W-1:0]      pixel_address,
    output logic [gtpr_pkg::PIX_W-1:0]       pixel_value,
    output logic                             last_pixel
);
    import gtpr_pkg::*;

    logic                 busy_reg, busy_next;
    logic [2:0]           row_reg, row_next;
    logic [2:0]           col_reg, col_next;
    logic [BITMAP_W-1:0]  bitmap_reg, bitmap_next;
    logic [ADDR_W-1:0]    row_addr_reg, row_addr_next;
    logic [LW_W-1:0]      step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [PIX_W-1:0]     value_reg, value_next;
    logic                 last_reg, last_next;

    logic out_adv;
    logic emit;
    logic at_end;
    logic done;
    logic load;

    always_comb
    begin
        out_adv    = !out_valid_reg || !out_stall;
        emit       = busy_reg && out_adv;
        at_end     = (row_reg == LAST_ROW) && (col_reg == LAST_COL);
        done       = emit && at_end;
        load_ready = !busy_reg || done;
        load       = load_valid && load_ready;

        busy_next      = busy_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        bitmap_next    = bitmap_reg;
        row_addr_next  = row_addr_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        value_next     = value_reg;
        last_next      = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            addr_next      = row_addr_reg + ADDR_W'(col_reg);
            value_next     = bitmap_reg[BITMAP_W-1] ? PIX_SET : PIX_CLEAR;
            last_next      = at_end;
            bitmap_next    = {bitmap_reg[BITMAP_W-2:0], 1'b0};
            if (col_reg == LAST_COL)
            begin
                col_next      = '0;
                row_next      = row_reg + 3'd1;
                row_addr_next = row_addr_reg + ADDR_W'(step_reg);
            end
            else
            begin
                col_next = col_reg + 3'd1;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            busy_next     = 1'b1;
            row_next      = '0;
            col_next      = '0;
            bitmap_next   = job.bitmap;
            row_addr_next = job.base_addr;
            step_next     = job.step;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bitmap_reg   <= bitmap_next;
        row_addr_reg <= row_addr_next;
        step_reg     <= step_next;
        addr_reg     <= addr_next;
        value_reg    <= value_next;
        last_reg     <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_value   = value_reg;
    assign last_pixel    = last_reg;

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (row_reg <= LAST_ROW))
        else $error("row counter past last row");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (col_reg <= LAST_COL))
        else $error("column counter past last column");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && row_reg == 3'd0 && col_reg == 3'd0))
        else $error("new glyph did not start at first pixel");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !load) |=> !busy_reg)
        else $error("sequencer still busy after last pixel");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && last_reg == $past(at_end)))
        else $error("last flag does not match final pixel");

endmodule

`default_nettype wire

// ----- sv/glyph_text_pixel_renderer.sv -----
// ----------------------------------------------------------------------------
// glyph_text_pixel_renderer
// draws one 6x7 text glyph per mapped item as 42 framebuffer pixel writes
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | in_valid/in_stall  | char_code, x_pos, y_pos
//  out      | out_valid/out_stall| pixel_address, pixel_value, last_pixel
//  cfg      | cfg_write          | cfg_index, cfg_data
//
//  a mapped code gives 42 pixel writes, one per cycle from the pixel sequencer
//  an unmapped code leaves the input register with no write, without waiting for the sequencer
//  the next item waits in the input register while a glyph is being drawn
//  reset clears control state; line_width returns to 320, frame_base to 0
//  out_stall holds the output register and the sequencer in place
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_text_pixel_renderer #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  char_code,
    input  wire logic [gtpr_pkg::POS_W-1:0]  x_pos,
    input  wire logic [gtpr_pkg::POS_W-1:0]  y_pos,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [gtpr_pkg::ADDR_W-1:0]      pixel_address,
    output logic [gtpr_pkg::PIX_W-1:0]       pixel_value,
    output logic                             last_pixel,
    input  wire logic                        cfg_write,
    input  wire logic                        cfg_index,
    input  wire logic [gtpr_pkg::CFG_W-1:0]  cfg_data
);
    import gtpr_pkg::*;

    logic [LW_W-1:0]   line_width_reg, line_width_next;
    logic [ADDR_W-1:0] frame_base_reg, frame_base_next;

    logic              a_valid_reg, a_valid_next;
    logic [CODE_W-1:0] a_code_reg;
    logic [POS_W-1:0]  a_x_reg;
    logic [POS_W-1:0]  a_y_reg;

    job_t job;
    logic load_ready;
    logic a_take;
    logic in_accept;

    always_comb
    begin
        line_width_next = line_width_reg;
        frame_base_next = frame_base_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LINE_WIDTH: line_width_next = cfg_data[LW_W-1:0];
                REG_FRAME_BASE: frame_base_next = cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        a_take    = a_valid_reg && (!job.mapped || load_ready);
        in_stall  = a_valid_reg && !a_take;
        in_accept = in_valid && !in_stall;
        if (in_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_take)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LW_W'(320);
            frame_base_reg <= '0;
            a_valid_reg    <= 1'b0;
        end
        else
        begin
            line_width_reg <= line_width_next;
            frame_base_reg <= frame_base_next;
            a_valid_reg    <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_code_reg <= char_code[CODE_W-1:0];
            a_x_reg    <= x_pos;
            a_y_reg    <= y_pos;
        end
    end

    gtpr_decode #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_decode (
        .code       (a_code_reg),
        .x_pos      (a_x_reg),
        .y_pos      (a_y_reg),
        .line_width (line_width_reg),
        .frame_base (frame_base_reg),
        .job        (job)
    );

    gtpr_pixel_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (job),
        .load_valid    (a_valid_reg && job.mapped),
        .load_ready    (load_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_address (pixel_address),
        .pixel_value   (pixel_value),
        .last_pixel    (last_pixel)
    );

endmodule

`default_nettype wire

// ----- tb/glyph_pixel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_pixel_checker
// watches the character and pixel channels of the glyph text pixel renderer,
// follows the configuration writes, predicts the 42 pixel writes of every
// mapped character accepted, compares each accepted pixel with the oldest one
// ----------------------------------------------------------------------------

module glyph_pixel_checker #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [7:0]                  char_code,
    input  logic [gtpr_pkg::POS_W-1:0]  x_pos,
    input  logic [gtpr_pkg::POS_W-1:0]  y_pos,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [gtpr_pkg::ADDR_W-1:0] pixel_address,
    input  logic [gtpr_pkg::PIX_W-1:0]  pixel_value,
    input  logic                        last_pixel,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [gtpr_pkg::CFG_W-1:0]  cfg_data,
    output int                          fail_count,
    output int                          pending,
    output int                          pixels_checked
);
    import gtpr_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PIX_W-1:0]  value;
        logic              last;
    } pixel_write_t;

    // six-bit glyph slices, five glyphs per word, msb first
    localparam logic [31:0] FONT_WORDS [64] = '{
        32'h70871C30, 32'h8988A250, 32'h88808290, 32'h88831C90,
        32'h888402F8, 32'h88882210, 32'h71CF9C10, 32'hF9CF9C70,
        32'h8228A288, 32'hF200A288, 32'h0BC11C78, 32'h0A222208,
        32'h8A222288, 32'h71C21C70, 32'h23C738F8, 32'h5228A480,
        32'h8A282280, 32'h8BC822F0, 32'hFA282280, 32'h8A28A480,
        32'h8BC738F8, 32'hF9C89C08, 32'h82288808, 32'h82088808,
        32'hF2EF8808, 32'h82288888, 32'h82288888, 32'h81C89C70,
        32'h8A08A270, 32'h920DA288, 32'hA20AB288, 32'hC20AAA88,
        32'hA208A688, 32'h9208A288, 32'h8BE8A270, 32'hF1CF1CF8,
        32'h8A28A220, 32'h8A28A020, 32'hF22F1C20, 32'h82AA0220,
        32'h82492220, 32'h81A89C20, 32'h8A28A288, 32'h8A28A288,
        32'h8A289488, 32'h8A2A8850, 32'h894A9420, 32'h894AA220,
        32'h70852220, 32'hF8011000, 32'h08020800, 32'h10840400,
        32'h20040470, 32'h40840400, 32'h80020800, 32'hF8011000,
        32'h70800000, 32'h88822200, 32'h08820400, 32'h108F8800,
        32'h20821000, 32'h00022200, 32'h20800020, 32'h00000000
    };

    logic [LW_W-1:0]   line_width_q = 11'd320;
    logic [ADDR_W-1:0] frame_base_q = '0;
    pixel_write_t      expected_pixels [$];
    pixel_write_t      seen;
    pixel_write_t      want;
    int                mismatches = 0;
    int                checked = 0;

    initial
    begin
        fail_count     = 0;
        pending        = 0;
        pixels_checked = 0;
    end

    function automatic logic [7:0] glyph_index(input logic [6:0] code);
        logic [7:0] g;
        g = GLYPH_NONE;
        if (code >= 7'h30 && code <= 7'h39)
            g = 8'(code - 7'h30);
        else if (code >= 7'h41 && code <= 7'h5A)
            g = 8'(code - 7'h41) + 8'd10;
        else if (code >= 7'h61 && code <= 7'h7A)
            g = 8'(code - 7'h61) + 8'd10;
        else
        begin
            case (code)
                7'h3A: g = 8'h24;   // colon
                7'h28: g = 8'h25;   // open paren
                7'h29: g = 8'h26;   // close paren
                7'h2D: g = 8'h27;   // minus
                7'h3F: g = 8'h28;   // question mark
                7'h21: g = 8'h29;   // exclamation
                7'h2B: g = 8'h2A;   // plus
                7'h25: g = 8'h2B;   // percent
                7'h2E: g = 8'h2C;   // period
                default: g = GLYPH_NONE;
            endcase
        end
        return g;
    endfunction

    task automatic predict_glyph(input logic [7:0] code, input logic [POS_W-1:0] x,
                                 input logic [POS_W-1:0] y);
        logic [7:0]   g;
        logic [31:0]  word;
        longint       pitch;
        longint       row_addr;
        int           word_base;
        int           shift0;
        pixel_write_t px;
        g = glyph_index(code[6:0]);
        if (g == GLYPH_NONE)
            return;
        pitch = (line_width_q > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : line_width_q;
        word_base = (int'(g) / 5) * ROWS;
        shift0 = (int'(g) % 5) * COLS;
        for (int r = 0; r < ROWS; r++)
        begin
            word = FONT_WORDS[(word_base + r) & 63];
            row_addr = longint'(frame_base_q) + pitch * (longint'(y) + r) + longint'(x);
            for (int c = 0; c < COLS; c++)
            begin
                px.address = ADDR_W'(row_addr + c);
                px.value = word[31 - shift0 - c] ? PIX_SET : PIX_CLEAR;
                px.last = (r == ROWS - 1) && (c == COLS - 1);
                expected_pixels.push_back(px);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_q = 11'd320;
            frame_base_q = '0;
            expected_pixels.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{pixel_address, pixel_value, last_pixel};
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t unexpected pixel: addr %h value %h last %b",
                                 $realtime, seen.address, seen.value, seen.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (seen.address !== want.address || seen.value !== want.value ||
                        seen.last !== want.last)
                    begin
                        if (mismatches < 10)
                            $display("%0t pixel mismatch: expected addr %h value %h last %b, %s",
                                     $realtime, want.address, want.value, want.last,
                                     $sformatf("got addr %h value %h last %b",
                                               seen.address, seen.value, seen.last));
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_glyph(char_code, x_pos, y_pos);
            if (cfg_write)
            begin
                if (cfg_index == REG_LINE_WIDTH)
                    line_width_q = cfg_data[LW_W-1:0];
                else
                    frame_base_q = cfg_data[ADDR_W-1:0];
            end
            pending <= expected_pixels.size();
        end
        fail_count     <= mismatches;
        pixels_checked <= checked;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// regression for the glyph text pixel renderer: directed characters at the
// reset settings, then random text under several line widths and frame bases,
// with random gaps and stalls on both channels and one long output hold-off
// ----------------------------------------------------------------------------

module tb_top;

    import gtpr_pkg::*;

    typedef enum int {GAPS_NONE, GAPS_FULL, GAPS_RARE} gap_mode_t;

    localparam int NUM_PHASES     = 8;
    localparam int CHARS_PER_PHASE = 52;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        char_code = '0;
    logic [POS_W-1:0]  x_pos = '0;
    logic [POS_W-1:0]  y_pos = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  pixel_value;
    logic              last_pixel;
    logic              cfg_write = 1'b0;
    logic              cfg_index = REG_LINE_WIDTH;
    logic [CFG_W-1:0]  cfg_data = '0;

    int        fail_count;
    int        pending;
    int        pixels_checked;
    gap_mode_t send_mode = GAPS_RARE;
    gap_mode_t sink_mode = GAPS_FULL;
    int        long_hold_cycles = 0;
    int        chars_sent = 0;
    string     glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz:()-?!+%.";

    always #5 clk = ~clk;

    glyph_text_pixel_renderer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_address (pixel_address),
        .pixel_value   (pixel_value),
        .last_pixel    (last_pixel),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    glyph_pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .x_pos          (x_pos),
        .y_pos          (y_pos),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_address  (pixel_address),
        .pixel_value    (pixel_value),
        .last_pixel     (last_pixel),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_checked (pixels_checked)
    );

    function automatic int draw_gap(input gap_mode_t mode);
        int g;
        case (mode)
            GAPS_NONE: g = 0;
            GAPS_FULL: g = $urandom_range(0, 18);
            default:   g = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) : 0;
        endcase
        return g;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int r;
        logic [POS_W-1:0] p;
        r = $urandom_range(0, 19);
        if (r == 0)
            p = '0;
        else if (r == 1)
            p = '1;
        else
            p = POS_W'($urandom);
        return p;
    endfunction

    function automatic logic [7:0] pick_code();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 15)
            c = 8'($urandom);
        else
        begin
            c = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
            if ($urandom_range(0, 3) == 0)
                c[7] = 1'b1;
        end
        return c;
    endfunction

    task automatic send_char(input logic [7:0] code, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y);
        int gap;
        gap = draw_gap(send_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= code;
        x_pos     <= x;
        y_pos     <= y;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        chars_sent++;
    endtask

    // block is idle once every pixel is out and an unmapped item has left
    task automatic drain_pixels();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] width_data,
                                input logic [CFG_W-1:0] base_data);
        cfg_write <= 1'b1;
        cfg_index <= REG_LINE_WIDTH;
        cfg_data  <= width_data;
        @(posedge clk);
        cfg_index <= REG_FRAME_BASE;
        cfg_data  <= base_data;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : pixel_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_cycles > 0)
            begin
                gap = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else
                gap = draw_gap(sink_mode);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("glyph_text_pixel_renderer regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] width_data;
        logic [CFG_W-1:0] base_data;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: width 320, base 0
        send_char("A", 10'd0, 10'd0);
        send_char("z", 10'h3FF, 10'h3FF);
        send_char(8'h00, 10'h2AA, 10'h155);
        send_char(8'h7F, 10'h155, 10'h2AA);
        send_char(8'hFF, 10'h3FF, 10'd0);
        send_char(8'hC1, 10'd0, 10'h3FF);
        send_char(" ", 10'd5, 10'd5);
        send_char("0", 10'h2AA, 10'h155);
        send_char("9", 10'h155, 10'h2AA);
        send_char(":", 10'd100, 10'd200);
        send_char("(", 10'd6, 10'd7);
        send_char(")", 10'd12, 10'd7);
        send_char("-", 10'd18, 10'd7);
        send_char("?", 10'd24, 10'd7);
        send_char("!", 10'd30, 10'd7);
        send_char("+", 10'd36, 10'd7);
        send_char("%", 10'd42, 10'd7);
        send_char(".", 10'd48, 10'd7);
        send_char("M", 10'd1017, 10'd1016);
        drain_pixels();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin width_data = 24'd1;      base_data = 24'd0;
                         send_mode = GAPS_NONE; sink_mode = GAPS_NONE; end
                1: begin width_data = 24'd0;      base_data = 24'hFFFFFF;
                         send_mode = GAPS_FULL; sink_mode = GAPS_FULL; end
                2: begin width_data = 24'd1024;   base_data = 24'hFFFF00;
                         send_mode = GAPS_RARE; sink_mode = GAPS_FULL; end
                3: begin width_data = 24'd2047;   base_data = 24'h123456;
                         send_mode = GAPS_FULL; sink_mode = GAPS_RARE; end
                4: begin width_data = 24'hABC401; base_data = 24'd0;
                         send_mode = GAPS_FULL; sink_mode = GAPS_NONE; end
                5: begin width_data = CFG_W'($urandom); base_data = CFG_W'($urandom);
                         send_mode = GAPS_RARE; sink_mode = GAPS_RARE; end
                6: begin width_data = CFG_W'($urandom); base_data = CFG_W'($urandom);
                         send_mode = GAPS_NONE; sink_mode = GAPS_FULL; end
                default: begin width_data = 24'd320; base_data = 24'd0;
                         send_mode = GAPS_FULL; sink_mode = GAPS_FULL; end
            endcase
            write_config(width_data, base_data);
            // back up the block while characters keep coming
            if (p == 0)
                long_hold_cycles = LONG_HOLD;
            for (int k = 0; k < CHARS_PER_PHASE; k++)
                send_char(pick_code(), pick_pos(), pick_pos());
            drain_pixels();
        end

        $display("sent %0d characters over %0d register settings, %0d pixel writes checked",
                 chars_sent, NUM_PHASES + 1, pixels_checked);
        $display("line widths 0 to 2047, frame bases up to 0xffffff, one %0d-cycle hold-off",
                 LONG_HOLD);
        if (fail_count == 0 && pending == 0)
            $display("glyph_text_pixel_renderer regression: pass");
        else
            $display("glyph_text_pixel_renderer regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/gtpr_pkg.sv
sv/gtpr_decode.sv
sv/gtpr_pixel_seq.sv
sv/glyph_text_pixel_renderer.sv
tb/glyph_pixel_checker.sv
tb/tb_top.sv
